[src/tdfe_pkg.sv]
// ---------------------------------------------------------------------------
// tdfe_pkg
// Shared types and constants for the table-driven state machine engine.
// ---------------------------------------------------------------------------
`default_nettype none

package tdfe_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned ID_W  = 8;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_INIT  = 2'd1,
    MODE_EVENT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_UNKNOWN_STATE = 2'd1,
    ST_NO_TRANSITION = 2'd2,
    ST_TABLE_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    id_t src;
    id_t evt;
    id_t dst;
    id_t act;
  } entry_t;

  typedef struct packed {
    logic seen;
    logic hit;
  } match_t;

  typedef struct packed {
    logic seen;
    logic hit;
    id_t  dst;
    id_t  act;
  } pick_t;

endpackage

`default_nettype wire

[src/tdfe_cell.sv]
// ---------------------------------------------------------------------------
// tdfe_cell
// One table entry. Entries shift one cell up on every append; the cell
// compares its entry against the broadcast key and registers the flags.
// ---------------------------------------------------------------------------
`default_nettype none

module tdfe_cell (
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire tdfe_pkg::entry_t entry_in,
  output tdfe_pkg::entry_t      entry_out,
  input  wire logic             cap_en,
  input  wire logic             valid,
  input  wire tdfe_pkg::id_t    key,
  input  wire tdfe_pkg::id_t    evt,
  output tdfe_pkg::match_t      match
);

  tdfe_pkg::entry_t entry;
  logic             src_eq;

  assign src_eq    = valid && (entry.src == key);
  assign entry_out = entry;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= entry_in;
    end
    if (cap_en) begin
      match.seen <= src_eq;
      match.hit  <= src_eq && (entry.evt == evt);
    end
  end

endmodule

`default_nettype wire

[src/tdfe_pick.sv]
// ---------------------------------------------------------------------------
// tdfe_pick
// Picks the oldest hitting cell (highest index) and returns its entry.
// ---------------------------------------------------------------------------
`default_nettype none

module tdfe_pick (
  input  wire tdfe_pkg::match_t match [tdfe_pkg::DEPTH],
  input  wire tdfe_pkg::entry_t entry [tdfe_pkg::DEPTH],
  output tdfe_pkg::pick_t       result
);

  localparam int unsigned N = tdfe_pkg::DEPTH;

  logic [N-1:0] rev;
  logic [N-1:0] onehot;
  logic         seen_any;

  // oldest entry sits at the top of the chain, so reverse and take lowest bit
  always_comb begin
    seen_any = 1'b0;
    for (int j = 0; j < N; j++) begin
      rev[j]   = match[N-1-j].hit;
      seen_any = seen_any | match[j].seen;
    end
    onehot = rev & (~rev + {{(N-1){1'b0}}, 1'b1});
  end

  always_comb begin
    result.seen = seen_any;
    result.hit  = |rev;
    result.dst  = '0;
    result.act  = '0;
    for (int j = 0; j < N; j++) begin
      if (onehot[j]) begin
        result.dst = result.dst | entry[N-1-j].dst;
        result.act = result.act | entry[N-1-j].act;
      end
    end
  end

endmodule

`default_nettype wire

[src/table_driven_fsm_engine_top.sv]
// ---------------------------------------------------------------------------
// table_driven_fsm_engine_top
// Path: input transfer, cell compare stage registers the flags, then the pick
//   stage and decode feed the result registers; one item in flight. A new item
//   waits until the last has left the pick stage and the output slot is free.
// Reset (rst, synchronous): entry count and present state cleared to zero,
//   no result pending. Cell contents are not cleared; cells at or above the
//   entry count are masked off.
// ---------------------------------------------------------------------------
`default_nettype none

module table_driven_fsm_engine_top (
  input  wire logic          clk,
  input  wire logic          rst,
  // request channel
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire logic [1:0]    mode,
  input  wire tdfe_pkg::id_t src_state,
  input  wire tdfe_pkg::id_t evt_code,
  input  wire tdfe_pkg::id_t next_state,
  input  wire tdfe_pkg::id_t act_code,
  // response channel
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output logic [1:0]         status,
  output tdfe_pkg::id_t      current_state,
  output tdfe_pkg::id_t      action_out,
  output logic               action_valid
);

  localparam int unsigned N = tdfe_pkg::DEPTH;

  // -------------------------------------------------------------------------
  // Control and architectural state
  // -------------------------------------------------------------------------
  logic            pend;          // item compared, result due next edge
  tdfe_pkg::cnt_t  entry_count;
  tdfe_pkg::id_t   present_state;
  tdfe_pkg::id_t   present_state_next;
  tdfe_pkg::mode_t mode_q;        // mode of the item in flight
  tdfe_pkg::id_t   key_q;         // init target
  logic            full_q;        // table was full when the add arrived

  tdfe_pkg::mode_t mode_in;
  logic            accept;
  logic            full;
  logic            do_shift;
  logic            rsp_free;
  tdfe_pkg::id_t   key;

  assign mode_in  = tdfe_pkg::mode_t'(mode);
  assign rsp_free = !rsp_valid || !rsp_stall;
  // accept only when nothing is in flight and the output slot frees up
  assign req_stall = pend || !rsp_free;
  assign accept    = req_valid && !req_stall;
  assign full      = (entry_count == tdfe_pkg::cnt_t'(N));
  assign do_shift  = accept && (mode_in == tdfe_pkg::MODE_ADD) && !full;
  // events match on the present state, init on the requested state
  assign key = (mode_in == tdfe_pkg::MODE_EVENT) ? present_state : src_state;

  // -------------------------------------------------------------------------
  // Cell chain: new entries enter cell 0 and push older ones up
  // -------------------------------------------------------------------------
  tdfe_pkg::entry_t new_entry;
  tdfe_pkg::entry_t chain [N];
  tdfe_pkg::match_t match [N];
  tdfe_pkg::pick_t  pick;

  assign new_entry = '{src: src_state, evt: evt_code, dst: next_state, act: act_code};

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic             cell_valid;
    tdfe_pkg::entry_t cell_in;

    assign cell_valid = (tdfe_pkg::cnt_t'(i) < entry_count);

    if (i == 0) begin : g_head
      assign cell_in = new_entry;
    end else begin : g_body
      assign cell_in = chain[i-1];
    end

    tdfe_cell u_cell (
      .clk       (clk),
      .shift_en  (do_shift),
      .entry_in  (cell_in),
      .entry_out (chain[i]),
      .cap_en    (accept),
      .valid     (cell_valid),
      .key       (key),
      .evt       (evt_code),
      .match     (match[i])
    );
  end

  tdfe_pick u_pick (
    .match  (match),
    .entry  (chain),
    .result (pick)
  );

  // -------------------------------------------------------------------------
  // Result decode for the item in flight
  // -------------------------------------------------------------------------
  tdfe_pkg::status_t status_next;
  tdfe_pkg::id_t     action_next;
  logic              action_valid_next;

  always_comb begin
    status_next        = tdfe_pkg::ST_OK;
    present_state_next = present_state;
    action_next        = '0;
    action_valid_next  = 1'b0;
    unique case (mode_q)
      tdfe_pkg::MODE_ADD: begin
        if (full_q) begin
          status_next = tdfe_pkg::ST_TABLE_FULL;
        end
      end
      tdfe_pkg::MODE_INIT: begin
        if (pick.seen) begin
          present_state_next = key_q;
        end else begin
          status_next = tdfe_pkg::ST_UNKNOWN_STATE;
        end
      end
      tdfe_pkg::MODE_EVENT: begin
        if (!pick.seen) begin
          status_next = tdfe_pkg::ST_UNKNOWN_STATE;
        end else if (!pick.hit) begin
          status_next = tdfe_pkg::ST_NO_TRANSITION;
        end else begin
          present_state_next = pick.dst;
          action_next        = pick.act;
          action_valid_next  = 1'b1;
        end
      end
      default: begin
        // unused mode: item ignored
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode_in;
      key_q  <= src_state;
      full_q <= full;
    end
    if (pend) begin
      status        <= status_next;
      current_state <= present_state_next;
      action_out    <= action_next;
      action_valid  <= action_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend          <= 1'b0;
      rsp_valid     <= 1'b0;
      entry_count   <= '0;
      present_state <= '0;
    end else begin
      pend <= accept;
      if (do_shift) begin
        entry_count <= entry_count + tdfe_pkg::cnt_t'(1);
      end
      if (pend) begin
        present_state <= present_state_next;
        rsp_valid     <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
